// ----- hdl/afff_pkg.sv -----
`timescale 1ns / 1ps

package afff_pkg;

    localparam int DEPTH_FRAMES = 8192;
    localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SAMPLE_W     = 16;
    localparam int FRAME_W      = 2 * SAMPLE_W;
    localparam int FILL_W       = 14;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_PULL  = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_UNDERRUN = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [FRAME_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_cmd;

    typedef struct packed {
        t_status           status;
        logic [FILL_W-1:0] fill;
        logic              hit;
    } t_result;

endpackage

// ----- hdl/afff_if.sv -----
`timescale 1ns / 1ps

interface afff_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [afff_pkg::KIND_W-1:0]            kind;
    logic signed [afff_pkg::SAMPLE_W-1:0]   left_in;
    logic signed [afff_pkg::SAMPLE_W-1:0]   right_in;
    logic                                   mono;

    modport source (output valid, kind, left_in, right_in, mono, input ready);
    modport sink   (input valid, kind, left_in, right_in, mono, output ready);
endinterface

interface afff_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [afff_pkg::SAMPLE_W-1:0]   left_out;
    logic signed [afff_pkg::SAMPLE_W-1:0]   right_out;
    logic [afff_pkg::STATUS_W-1:0]          status;
    logic [afff_pkg::FILL_W-1:0]            fill_level;

    modport source (output valid, left_out, right_out, status, fill_level, input ready);
    modport sink   (input valid, left_out, right_out, status, fill_level, output ready);
endinterface

// ----- hdl/afff_store.sv -----
`timescale 1ns / 1ps

module afff_store (
    input  logic                          i_clk,
    input  afff_pkg::t_mem_cmd            i_cmd,
    output logic [afff_pkg::FRAME_W-1:0]  o_rd_data
);

    logic [afff_pkg::FRAME_W-1:0] r_mem [afff_pkg::DEPTH_FRAMES];
    logic [afff_pkg::FRAME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rd_data <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/afff_ctrl.sv -----
`timescale 1ns / 1ps

module afff_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [afff_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [afff_pkg::SAMPLE_W-1:0]  i_left,
    input  logic signed [afff_pkg::SAMPLE_W-1:0]  i_right,
    input  logic                                  i_mono,
    input  logic                                  i_enable,
    output afff_pkg::t_mem_cmd                    o_mem,
    output afff_pkg::t_result                     o_res
);

    localparam logic [afff_pkg::CNT_W-1:0] FULL_COUNT =
        afff_pkg::CNT_W'(afff_pkg::DEPTH_FRAMES);

    logic [afff_pkg::ADDR_W-1:0] r_rd_ptr;
    logic [afff_pkg::ADDR_W-1:0] n_rd_ptr;
    logic [afff_pkg::CNT_W-1:0]  r_count;
    logic [afff_pkg::CNT_W-1:0]  n_count;
    afff_pkg::t_status           status;
    logic                        push_ok;
    logic                        hit;
    logic [afff_pkg::SAMPLE_W-1:0] right_sel;

    assign right_sel = i_mono ? i_left : i_right;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        status   = afff_pkg::ST_OK;
        push_ok  = 1'b0;
        hit      = 1'b0;
        o_mem.waddr = r_rd_ptr + r_count[afff_pkg::ADDR_W-1:0];
        case (afff_pkg::t_kind'(i_kind))
            afff_pkg::KIND_PUSH: begin
                if (!i_enable) begin
                    status = afff_pkg::ST_IGNORED;
                end else if (r_count == FULL_COUNT) begin
                    // drop oldest, overwrite its slot
                    push_ok     = 1'b1;
                    n_rd_ptr    = r_rd_ptr + 1'b1;
                    o_mem.waddr = r_rd_ptr;
                    status      = afff_pkg::ST_DROPPED;
                end else begin
                    push_ok = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            afff_pkg::KIND_PULL: begin
                if (r_count == '0) begin
                    status = afff_pkg::ST_UNDERRUN;
                end else begin
                    hit      = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            afff_pkg::KIND_FLUSH: begin
                n_rd_ptr = '0;
                n_count  = '0;
            end
            default: begin
            end
        endcase
        o_mem.we    = i_accept && push_ok;
        o_mem.wdata = {right_sel, i_left};
        o_mem.re    = i_accept && hit;
        o_mem.raddr = r_rd_ptr;
        o_res.status = status;
        o_res.fill   = afff_pkg::FILL_W'(n_count);
        o_res.hit    = hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("frame count above capacity");

    a_drop_keeps_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && status == afff_pkg::ST_DROPPED) |=> r_count == FULL_COUNT)
        else $error("count left full state on drop");

    a_pull_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && hit) |=> (r_count == $past(r_count) - 1'b1)
                              && (r_rd_ptr == $past(r_rd_ptr) + 1'b1))
        else $error("pull did not advance pointer and count");

    a_read_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.re |-> r_count != '0)
        else $error("read issued from empty store");

endmodule

// ----- hdl/audio_frame_fifo_drop_oldest_unit.sv -----
`timescale 1ns / 1ps
// An accepted input's result is registered and shown on the output in the next cycle.
// Throughput: one item per cycle while the output is taken every cycle.
// The single registered read of the frame memory lines up with the registered result.
// Reset clears read pointer, frame count, enable and the output valid flag;
// frame memory contents are not cleared.

module audio_frame_fifo_drop_oldest_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    afff_in_if.sink           i_in,
    afff_out_if.source        o_out
);

    logic                          r_enable;
    logic                          r_valid;
    afff_pkg::t_result             r_res;
    logic                          accept;
    afff_pkg::t_mem_cmd            mem_cmd;
    afff_pkg::t_result             res;
    logic [afff_pkg::FRAME_W-1:0]  rd_data;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    afff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (i_in.kind),
        .i_left   (i_in.left_in),
        .i_right  (i_in.right_in),
        .i_mono   (i_in.mono),
        .i_enable (r_enable),
        .o_mem    (mem_cmd),
        .o_res    (res)
    );

    afff_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.left_out   = r_res.hit ? rd_data[afff_pkg::SAMPLE_W-1:0] : '0;
    assign o_out.right_out  = r_res.hit ? rd_data[afff_pkg::FRAME_W-1:afff_pkg::SAMPLE_W] : '0;
    assign o_out.status     = r_res.status;
    assign o_out.fill_level = r_res.fill;

    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.hit) |-> r_res.status == afff_pkg::ST_OK)
        else $error("frame returned with non-ok status");

    a_ignored_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_valid && res.status == afff_pkg::ST_IGNORED) |=>
            r_res.fill == $past(r_res.fill))
        else $error("ignored push changed fill level");

    a_underrun_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status == afff_pkg::ST_UNDERRUN) |-> r_res.fill == '0)
        else $error("underrun with frames held");

endmodule
